// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/plm_pkg.sv
// shared types, codes and defaults for the positional list engine
// no dependencies
package plm_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int DATA_W           = 32;
    localparam int POS_W            = 6;

    localparam logic [2:0] OP_INS_FRONT  = 3'd0;
    localparam logic [2:0] OP_INS_BACK   = 3'd1;
    localparam logic [2:0] OP_INS_BEFORE = 3'd2;
    localparam logic [2:0] OP_INS_AFTER  = 3'd3;
    localparam logic [2:0] OP_DEL_FRONT  = 3'd4;
    localparam logic [2:0] OP_DEL_BACK   = 3'd5;
    localparam logic [2:0] OP_DEL_AT     = 3'd6;
    localparam logic [2:0] OP_READ_ALL   = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] CMD_HOLD = 2'd0;
    localparam logic [1:0] CMD_INS  = 2'd1;
    localparam logic [1:0] CMD_DEL  = 2'd2;
    localparam logic [1:0] CMD_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] head;
    } plm_ctl_t;

endpackage

// File: rtl/positional_list_engine.sv
// top level of the positional list engine: control, decode and the cell chain
// depends on plm_pkg, plm_cell and assert_macros.svh
//
// usage:
//   a request (operation, value, position) is a transfer at a rising edge with
//   start high and busy low. results appear on status, data, data_valid and
//   last for exactly one cycle, marked by strobe; the receiver cannot stall.
//   inserts and deletes update the cell chain and give a single result in the
//   next cycle; busy stays low, so a new request may follow in every cycle.
//   a read-all raises busy while the chain rotates through cell 0 once;
//   results follow one per cycle, each in the cycle after the step that
//   reads it from cell 0, the final one with last high. an empty list
//   gives one empty result instead. throughput is one request per cycle
//   while busy is low; a read-all holds off new requests until the chain
//   has rotated through its head cell once.
//   reset clears the element count and the control state; cell contents
//   are undefined until written and are never read before then.
`include "assert_macros.svh"

module positional_list_engine import plm_pkg::*; #(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data,
    output logic                     data_valid,
    output logic                     last
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                     state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     strobe_reg, strobe_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     dvalid_reg, dvalid_next;
    logic                     last_reg, last_next;

    logic signed [DATA_W-1:0] cells_q [CAPACITY];
    plm_ctl_t                 ctl;
    logic [IDX_W-1:0]         cell_idx;
    logic [IDX_W-1:0]         tail;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     bad_pos;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         n_x;

    assign busy   = (state_reg == S_READ);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_MAX);
    assign empty  = (count_reg == '0);
    assign pos_x  = CMP_W'(position);
    assign n_x    = CMP_W'(count_reg);
    assign bad_pos = (pos_x == '0) || (pos_x > n_x);
    assign tail   = IDX_W'(count_reg - 1'b1);

    always_comb
    begin
        ctl.cmd     = CMD_HOLD;
        ctl.value   = value;
        ctl.head    = cells_q[0];
        cell_idx    = '0;
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        strobe_next = 1'b0;
        status_next = ST_OK;
        data_next   = '0;
        dvalid_next = 1'b0;
        last_next   = 1'b0;

        if (state_reg == S_READ)
        begin
            ctl.cmd     = CMD_ROT;
            strobe_next = 1'b1;
            data_next   = cells_q[0];
            dvalid_next = 1'b1;
            rd_cnt_next = rd_cnt_reg + 1'b1;
            if (rd_cnt_reg == tail)
            begin
                last_next  = 1'b1;
                state_next = S_IDLE;
            end
        end
        else if (accept)
        begin
            strobe_next = 1'b1;
            last_next   = 1'b1;
            case (operation) inside
                OP_INS_FRONT, OP_INS_BACK, OP_INS_BEFORE, OP_INS_AFTER:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else if (operation == OP_INS_FRONT)
                        cell_idx = '0;
                    else if (operation == OP_INS_BACK)
                        cell_idx = IDX_W'(count_reg);
                    else if (operation == OP_INS_BEFORE)
                    begin
                        if (pos_x == CMP_W'(1))
                            cell_idx = '0;
                        else if (bad_pos)
                            status_next = ST_INVALID;
                        else
                            cell_idx = IDX_W'(pos_x - 1'b1);
                    end
                    else
                    begin
                        if (empty)
                            status_next = ST_EMPTY;
                        else if (bad_pos)
                            status_next = ST_INVALID;
                        else
                            cell_idx = IDX_W'(pos_x);
                    end
                    if (status_next == ST_OK)
                    begin
                        ctl.cmd    = CMD_INS;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
                begin
                    if (operation == OP_DEL_AT && pos_x != CMP_W'(1) && bad_pos)
                        status_next = ST_INVALID;
                    else if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        if (operation == OP_DEL_FRONT)
                            cell_idx = '0;
                        else if (operation == OP_DEL_BACK)
                            cell_idx = tail;
                        else
                            cell_idx = IDX_W'(pos_x - 1'b1);
                        ctl.cmd     = CMD_DEL;
                        count_next  = count_reg - 1'b1;
                        data_next   = cells_q[cell_idx];
                        dvalid_next = 1'b1;
                    end
                end
                default:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        strobe_next = 1'b0;
                        last_next   = 1'b0;
                        state_next  = S_READ;
                        rd_cnt_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_cnt_reg <= '0;
            strobe_reg <= 1'b0;
            status_reg <= ST_OK;
            data_reg   <= '0;
            dvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
            strobe_reg <= strobe_next;
            status_reg <= status_next;
            data_reg   <= data_next;
            dvalid_reg <= dvalid_next;
            last_reg   <= last_next;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cells_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_lastc
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cells_q[g+1];
        end

        plm_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .idx   (cell_idx),
            .tail  (tail),
            .left  (left_d),
            .right (right_d),
            .q     (cells_q[g])
        );
    end

    assign strobe     = strobe_reg;
    assign status     = status_reg;
    assign data       = data_reg;
    assign data_valid = dvalid_reg;
    assign last       = last_reg;

    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX,
                 "count above capacity")
    `ASSERT_IMPL(a_read_nonempty, clk, rst_n, state_reg == S_READ, count_reg != '0,
                 "read of empty list")
    `ASSERT_NEXT(a_read_strobe, clk, rst_n, state_reg == S_READ, strobe,
                 "read cycle without result")
    `ASSERT_NEXT(a_single_result, clk, rst_n, accept && operation != OP_READ_ALL,
                 strobe && last, "request without final result")
    `ASSERT_IMPL(a_full_status, clk, rst_n, strobe && status == ST_FULL,
                 count_reg == CNT_MAX, "full status on list with room")

endmodule

// File: rtl/plm_cell.sv
// one storage cell of the list chain
// depends on plm_pkg
module plm_cell import plm_pkg::*; #(
    parameter int IDX_W = 5,
    parameter int INDEX = 0
) (
    input  logic                     clk,
    input  plm_ctl_t                 ctl,
    input  logic [IDX_W-1:0]         idx,
    input  logic [IDX_W-1:0]         tail,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] q
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] q_next;

    always_comb
    begin
        q_next = q_reg;
        case (ctl.cmd)
            CMD_INS:
            begin
                if (MY_IDX > idx)
                    q_next = left;
                else if (MY_IDX == idx)
                    q_next = ctl.value;
            end
            CMD_DEL:
            begin
                if (MY_IDX >= idx)
                    q_next = right;
            end
            CMD_ROT:
            begin
                if (MY_IDX < tail)
                    q_next = right;
                else if (MY_IDX == tail)
                    q_next = ctl.head;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
